// ===== design/assert_macros.svh =====
// assertion macros used by stream_timeout_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/stt_pkg.sv =====
// shared types and constants of the stream timeout table
`default_nettype none

package stt_pkg;

    localparam int ID_W          = 16;
    localparam int TIME_W        = 31;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT_RESET = 31'd100;

    typedef enum logic [1:0] {
        OP_ELAPSE   = 2'd0,
        OP_REGISTER = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_IGNORE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_KEY  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_SORT = 2'd2,
        S_EMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   stream;
        logic [TIME_W-1:0] remaining;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/stt_ram.sv =====
// entry memory: one write port, one read port with registered data
`default_nettype none

module stt_ram #(
    parameter int DEPTH = stt_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(stt_pkg::DEPTH_DEFAULT)
) (
    input  wire logic            clk,
    input  wire logic [IDX_W-1:0] rd_addr,
    output stt_pkg::entry_t      rd_data,
    input  wire logic            wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire stt_pkg::entry_t wr_data
);

    stt_pkg::entry_t mem [DEPTH];
    stt_pkg::entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/stream_timeout_table.sv =====
// top level of the stream timeout table: control sequencer around the entry memory
//
//   channel | signals                                          | direction
//   cmd     | cmd_valid, cmd_stall, opcode, stream_id, amount_ms | in
//   rsp     | rsp_valid, rsp_stall, status, expired_valid,       | out
//           | expired_id, min_timeout, last                     |
//   cfg     | cfg_write_en, cfg_write_data                      | in
//
// one item at a time; every table scan reads the memory once per entry
// register, clear and elapse each scan the table; an ignored command skips the scan
// a clear that removes the minimum adds a second scan to rebuild the minimum
// an elapse with expired streams adds one ordering scan per expired stream
// a stalled result holds the sequencer in its emit step; cmd_stall stays high until idle
// reset clears valid bits, sets minimum and default timeout to 100; the memory needs no clearing
`default_nettype none

`include "assert_macros.svh"

module stream_timeout_table #(
    parameter int TABLE_DEPTH = stt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_stall,
    input  wire logic [1:0]                 opcode,
    input  wire logic [stt_pkg::ID_W-1:0]   stream_id,
    input  wire logic [stt_pkg::TIME_W-1:0] amount_ms,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic [1:0]                      status,
    output logic                            expired_valid,
    output logic [stt_pkg::ID_W-1:0]        expired_id,
    output logic [stt_pkg::TIME_W-1:0]      min_timeout,
    output logic                            last,
    input  wire logic                       cfg_write_en,
    input  wire logic [stt_pkg::TIME_W-1:0] cfg_write_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    stt_pkg::state_t state_reg, state_next;
    stt_pkg::op_t    op_reg, op_next;
    logic [stt_pkg::ID_W-1:0]   id_reg, id_next;
    logic [stt_pkg::TIME_W-1:0] amt_reg, amt_next;
    logic                       silent_reg, silent_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       pend_reg, pend_next;
    logic [IDX_W-1:0]           pidx_reg, pidx_next;
    logic [TABLE_DEPTH-1:0]     valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0]     gone_reg, gone_next;
    logic [stt_pkg::TIME_W-1:0] acc_reg, acc_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           fidx_reg, fidx_next;
    logic [stt_pkg::TIME_W-1:0] frem_reg, frem_next;
    logic                       bhave_reg, bhave_next;
    logic [stt_pkg::ID_W-1:0]   bid_reg, bid_next;
    logic [IDX_W-1:0]           bidx_reg, bidx_next;
    logic [stt_pkg::TIME_W-1:0] cur_min_reg, cur_min_next;
    logic [stt_pkg::TIME_W-1:0] dflt_reg;

    // pending result fields
    stt_pkg::status_t           res_st_reg, res_st_next;
    logic                       res_expv_reg, res_expv_next;
    logic [stt_pkg::ID_W-1:0]   res_id_reg, res_id_next;
    logic                       res_last_reg, res_last_next;

    // output register
    logic                       ov_reg, ov_next;
    logic [1:0]                 ost_reg, ost_next;
    logic                       oexpv_reg, oexpv_next;
    logic [stt_pkg::ID_W-1:0]   oid_reg, oid_next;
    logic [stt_pkg::TIME_W-1:0] omin_reg, omin_next;
    logic                       olast_reg, olast_next;

    // memory ports
    logic [IDX_W-1:0]  rd_addr;
    stt_pkg::entry_t   rd_data;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    stt_pkg::entry_t   mem_wdata;

    logic [IDX_W-1:0]           free_idx;
    logic                       scan_done;
    logic [TABLE_DEPTH-1:0]     gone_left;
    logic [stt_pkg::TIME_W-1:0] rem_left;

    stt_ram #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // gone set once the current best is reported
    always_comb
    begin
        gone_left = gone_reg;
        gone_left[bidx_reg] = 1'b0;
    end

    assign scan_done = (cnt_reg == DEPTH_CNT) && !pend_reg;
    assign rd_addr   = cnt_reg[IDX_W-1:0];
    assign rem_left  = rd_data.remaining - amt_reg;

    // default timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_reg <= stt_pkg::DEFAULT_TIMEOUT_RESET;
        end
        else if (cfg_write_en)
        begin
            dflt_reg <= cfg_write_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= stt_pkg::S_IDLE;
            valid_reg   <= '0;
            gone_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            cur_min_reg <= stt_pkg::DEFAULT_TIMEOUT_RESET;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            gone_reg    <= gone_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            cur_min_reg <= cur_min_next;
            ov_reg      <= ov_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        amt_reg      <= amt_next;
        silent_reg   <= silent_next;
        pidx_reg     <= pidx_next;
        acc_reg      <= acc_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        frem_reg     <= frem_next;
        bhave_reg    <= bhave_next;
        bid_reg      <= bid_next;
        bidx_reg     <= bidx_next;
        res_st_reg   <= res_st_next;
        res_expv_reg <= res_expv_next;
        res_id_reg   <= res_id_next;
        res_last_reg <= res_last_next;
        ost_reg      <= ost_next;
        oexpv_reg    <= oexpv_next;
        oid_reg      <= oid_next;
        omin_reg     <= omin_next;
        olast_reg    <= olast_next;
    end

    // sequencer: next state, memory access and result building
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        amt_next      = amt_reg;
        silent_next   = silent_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        valid_next    = valid_reg;
        gone_next     = gone_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        frem_next     = frem_reg;
        bhave_next    = bhave_reg;
        bid_next      = bid_reg;
        bidx_next     = bidx_reg;
        cur_min_next  = cur_min_reg;
        res_st_next   = res_st_reg;
        res_expv_next = res_expv_reg;
        res_id_next   = res_id_reg;
        res_last_next = res_last_reg;
        ov_next       = ov_reg && rsp_stall;
        ost_next      = ost_reg;
        oexpv_next    = oexpv_reg;
        oid_next      = oid_reg;
        omin_next     = omin_reg;
        olast_next    = olast_reg;
        mem_we        = 1'b0;
        mem_waddr     = pidx_reg;
        mem_wdata     = rd_data;
        cmd_stall     = 1'b1;

        // read issue, shared by both scans
        if (state_reg == stt_pkg::S_SCAN || state_reg == stt_pkg::S_SORT)
        begin
            if (cnt_reg != DEPTH_CNT)
            begin
                cnt_next  = cnt_reg + 1'b1;
                pend_next = 1'b1;
                pidx_next = cnt_reg[IDX_W-1:0];
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        case (state_reg)
            stt_pkg::S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    op_next       = stt_pkg::op_t'(opcode);
                    id_next       = stream_id;
                    amt_next      = amount_ms;
                    silent_next   = 1'b0;
                    cnt_next      = '0;
                    pend_next     = 1'b0;
                    gone_next     = '0;
                    acc_next      = dflt_reg;
                    found_next    = 1'b0;
                    res_st_next   = stt_pkg::ST_OK;
                    res_expv_next = 1'b0;
                    res_id_next   = '0;
                    res_last_next = 1'b1;
                    if (stt_pkg::op_t'(opcode) == stt_pkg::OP_IGNORE)
                    begin
                        state_next = stt_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = stt_pkg::S_SCAN;
                    end
                end
            end

            stt_pkg::S_SCAN:
            begin
                // process the entry read in the previous cycle
                if (pend_reg && valid_reg[pidx_reg])
                begin
                    if (op_reg == stt_pkg::OP_ELAPSE)
                    begin
                        if (rd_data.remaining <= amt_reg)
                        begin
                            valid_next[pidx_reg] = 1'b0;
                            gone_next[pidx_reg]  = 1'b1;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            mem_wdata.remaining = rem_left;
                            if (rem_left < acc_reg)
                            begin
                                acc_next = rem_left;
                            end
                        end
                    end
                    else if (rd_data.stream == id_reg)
                    begin
                        found_next = 1'b1;
                        fidx_next  = pidx_reg;
                        frem_next  = rd_data.remaining;
                    end
                end

                // end of scan
                if (scan_done)
                begin
                    case (op_reg)
                        stt_pkg::OP_ELAPSE:
                        begin
                            cur_min_next = acc_reg;
                            if (!silent_reg && (gone_reg != '0))
                            begin
                                cnt_next   = '0;
                                bhave_next = 1'b0;
                                state_next = stt_pkg::S_SORT;
                            end
                            else
                            begin
                                state_next = stt_pkg::S_EMIT;
                            end
                        end
                        stt_pkg::OP_REGISTER:
                        begin
                            state_next = stt_pkg::S_EMIT;
                            if (found_reg)
                            begin
                                res_st_next = stt_pkg::ST_KEY;
                            end
                            else if (&valid_reg)
                            begin
                                res_st_next = stt_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = free_idx;
                                mem_wdata.stream     = id_reg;
                                mem_wdata.remaining  = amt_reg;
                                valid_next[free_idx] = 1'b1;
                                if (amt_reg < cur_min_reg)
                                begin
                                    cur_min_next = amt_reg;
                                end
                            end
                        end
                        stt_pkg::OP_CLEAR:
                        begin
                            if (!found_reg)
                            begin
                                res_st_next = stt_pkg::ST_KEY;
                                state_next  = stt_pkg::S_EMIT;
                            end
                            else
                            begin
                                valid_next[fidx_reg] = 1'b0;
                                if (frem_reg == cur_min_reg)
                                begin
                                    // zero-time elapse to rebuild the minimum
                                    op_next     = stt_pkg::OP_ELAPSE;
                                    silent_next = 1'b1;
                                    amt_next    = '0;
                                    cnt_next    = '0;
                                    gone_next   = '0;
                                    acc_next    = dflt_reg;
                                end
                                else
                                begin
                                    state_next = stt_pkg::S_EMIT;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = stt_pkg::S_EMIT;
                        end
                    endcase
                end
            end

            stt_pkg::S_SORT:
            begin
                // smallest id among expired entries
                if (pend_reg && gone_reg[pidx_reg])
                begin
                    if (!bhave_reg || (rd_data.stream < bid_reg))
                    begin
                        bhave_next = 1'b1;
                        bid_next   = rd_data.stream;
                        bidx_next  = pidx_reg;
                    end
                end
                if (scan_done)
                begin
                    gone_next     = gone_left;
                    res_st_next   = stt_pkg::ST_OK;
                    res_expv_next = 1'b1;
                    res_id_next   = bid_reg;
                    res_last_next = (gone_left == '0);
                    state_next    = stt_pkg::S_EMIT;
                end
            end

            stt_pkg::S_EMIT:
            begin
                if (!ov_reg || !rsp_stall)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_st_reg;
                    oexpv_next = res_expv_reg;
                    oid_next   = res_id_reg;
                    omin_next  = cur_min_reg;
                    olast_next = res_last_reg;
                    if (res_last_reg)
                    begin
                        state_next = stt_pkg::S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        bhave_next = 1'b0;
                        state_next = stt_pkg::S_SORT;
                    end
                end
            end

            default:
            begin
                state_next = stt_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid     = ov_reg;
    assign status        = ost_reg;
    assign expired_valid = oexpv_reg;
    assign expired_id    = oid_reg;
    assign min_timeout   = omin_reg;
    assign last          = olast_reg;

    // an expired entry is never live at the same time
    `ASSERT_CLK(a_gone_not_valid, clk, rst_n, (gone_reg & valid_reg) == '0,
        "expired mark on a live entry")

    // the ordering scan runs only while expired entries remain
    `ASSERT_IMPL(a_sort_has_work, clk, rst_n, state_reg == stt_pkg::S_SORT, gone_reg != '0,
        "ordering scan with nothing to report")

    // an expired stream is always reported with status ok
    `ASSERT_IMPL(a_expired_ok, clk, rst_n, rsp_valid && expired_valid, status == stt_pkg::ST_OK,
        "expired stream reported with an error status")

endmodule

`default_nettype wire
